### hdl/brl_pkg.sv
// Package for the banded line rasterizer.
// Holds shared constants, codes and the types passed between its modules.
// No dependencies.
package brl_pkg;

    localparam int DEF_COORD_BITS = 10;
    localparam int OFFSET_BITS    = 10;
    localparam int ROW_W_BITS     = 10;
    localparam int BAND_BITS      = 11;
    localparam int COLOR_BITS     = 16;
    localparam int INDEX_BITS     = 16;
    localparam int FRAC_BITS      = 16;
    localparam int ACC_BITS       = 32;
    localparam int QUO_BITS       = 17;
    localparam int DIV_CNT_BITS   = 5;
    localparam int ADDR_BITS      = 5;
    localparam int DATA_BITS      = 32;

    localparam logic [ACC_BITS-1:0]   ROUND_HALF = 32'h0000_8000;

    localparam logic [ROW_W_BITS-1:0]  RST_ROW_WIDTH  = 10'd320;
    localparam logic [BAND_BITS-1:0]   RST_BAND_FIRST = 11'd0;
    localparam logic [BAND_BITS-1:0]   RST_BAND_LAST  = 11'd15;
    localparam logic [OFFSET_BITS-1:0] RST_OFFSET_X   = 10'd0;
    localparam logic [OFFSET_BITS-1:0] RST_OFFSET_Y   = 10'd0;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        REG_ROW_WIDTH  = 3'd0,
        REG_BAND_FIRST = 3'd1,
        REG_BAND_LAST  = 3'd2,
        REG_OFFSET_X   = 3'd3,
        REG_OFFSET_Y   = 3'd4
    } reg_idx_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_DIVIDE = 1'b1
    } state_t;

    typedef struct packed {
        logic [ROW_W_BITS-1:0]  row_width;
        logic [BAND_BITS-1:0]   band_first;
        logic [BAND_BITS-1:0]   band_last;
        logic [OFFSET_BITS-1:0] offset_x;
        logic [OFFSET_BITS-1:0] offset_y;
    } cfg_t;

    typedef struct packed {
        logic start;     // load a new line and prime the divider
        logic step;      // emit one pixel of the current line
        logic div_step;  // one restoring division iteration
        logic div_last;  // final iteration, store the increment
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
        logic reject;    // presented start item misses the band
    } ctrl_status_t;

endpackage

### hdl/brl_cfg.sv
// Configuration register file with an APB-style write/read port.
// Depends on brl_pkg.
module brl_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [brl_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [brl_pkg::DATA_BITS-1:0]   pwdata,
    output logic [brl_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready,
    output brl_pkg::cfg_t                   cfg
);

    brl_pkg::cfg_t    cfg_reg;
    brl_pkg::cfg_t    cfg_next;
    brl_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx   = brl_pkg::reg_idx_t'(paddr[brl_pkg::ADDR_BITS-1:2]);
    assign wr_en = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                brl_pkg::REG_ROW_WIDTH:
                    cfg_next.row_width  = pwdata[brl_pkg::ROW_W_BITS-1:0];
                brl_pkg::REG_BAND_FIRST:
                    cfg_next.band_first = pwdata[brl_pkg::BAND_BITS-1:0];
                brl_pkg::REG_BAND_LAST:
                    cfg_next.band_last  = pwdata[brl_pkg::BAND_BITS-1:0];
                brl_pkg::REG_OFFSET_X:
                    cfg_next.offset_x   = pwdata[brl_pkg::OFFSET_BITS-1:0];
                brl_pkg::REG_OFFSET_Y:
                    cfg_next.offset_y   = pwdata[brl_pkg::OFFSET_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            brl_pkg::REG_ROW_WIDTH:  prdata = brl_pkg::DATA_BITS'(cfg_reg.row_width);
            brl_pkg::REG_BAND_FIRST: prdata = brl_pkg::DATA_BITS'(cfg_reg.band_first);
            brl_pkg::REG_BAND_LAST:  prdata = brl_pkg::DATA_BITS'(cfg_reg.band_last);
            brl_pkg::REG_OFFSET_X:   prdata = brl_pkg::DATA_BITS'(cfg_reg.offset_x);
            brl_pkg::REG_OFFSET_Y:   prdata = brl_pkg::DATA_BITS'(cfg_reg.offset_y);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_width  <= brl_pkg::RST_ROW_WIDTH;
            cfg_reg.band_first <= brl_pkg::RST_BAND_FIRST;
            cfg_reg.band_last  <= brl_pkg::RST_BAND_LAST;
            cfg_reg.offset_x   <= brl_pkg::RST_OFFSET_X;
            cfg_reg.offset_y   <= brl_pkg::RST_OFFSET_Y;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/brl_ctrl.sv
// Controller: accepts items, sequences the per-line division.
// Depends on brl_pkg.
module brl_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_op,
    output logic                  in_ready,
    input  brl_pkg::ctrl_status_t status,
    output brl_pkg::ctrl_cmd_t    cmd
);

    brl_pkg::state_t                  state_reg;
    brl_pkg::state_t                  state_next;
    logic [brl_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic [brl_pkg::DIV_CNT_BITS-1:0] cnt_next;
    logic                             accept;
    logic                             start_go;

    assign accept   = in_valid && in_ready;
    assign start_go = accept && (brl_pkg::op_t'(in_op) == brl_pkg::OP_START)
                      && !status.reject;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brl_pkg::ST_IDLE:
            begin
                if (start_go)
                    state_next = brl_pkg::ST_DIVIDE;
            end
            brl_pkg::ST_DIVIDE:
            begin
                if (cnt_reg == '0)
                    state_next = brl_pkg::ST_IDLE;
            end
            default:
                state_next = brl_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.start    = 1'b0;
        cmd.step     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.div_last = 1'b0;
        unique case (state_reg)
            brl_pkg::ST_IDLE:
            begin
                in_ready  = status.out_free;
                cmd.start = accept && (brl_pkg::op_t'(in_op) == brl_pkg::OP_START);
                cmd.step  = accept && (brl_pkg::op_t'(in_op) == brl_pkg::OP_STEP);
            end
            brl_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = (cnt_reg == '0);
            end
            default:
                in_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start_go)
            cnt_next = brl_pkg::DIV_CNT_BITS'(brl_pkg::QUO_BITS - 1);
        else if (state_reg == brl_pkg::ST_DIVIDE && cnt_reg != '0)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brl_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### hdl/brl_datapath.sv
// Datapath: endpoint setup, restoring divider, line stepper, output register.
// Depends on brl_pkg; driven by brl_ctrl commands.
module brl_datapath
#(
    parameter int COORD_BITS = brl_pkg::DEF_COORD_BITS,
    parameter int POS_BITS   = brl_pkg::DEF_COORD_BITS + 1
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  brl_pkg::cfg_t                    cfg,
    input  brl_pkg::ctrl_cmd_t               cmd,
    output brl_pkg::ctrl_status_t            status,
    input  logic [COORD_BITS-1:0]            x_start,
    input  logic [COORD_BITS-1:0]            y_start,
    input  logic [COORD_BITS-1:0]            x_end,
    input  logic [COORD_BITS-1:0]            y_end,
    input  logic [brl_pkg::COLOR_BITS-1:0]   line_color,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic                             write_valid,
    output logic [brl_pkg::INDEX_BITS-1:0]   pixel_index,
    output logic [brl_pkg::COLOR_BITS-1:0]   pixel_color,
    output logic                             line_done
);

    localparam int IW = brl_pkg::INDEX_BITS;
    localparam int AW = brl_pkg::ACC_BITS;
    localparam int QW = brl_pkg::QUO_BITS;

    // line state
    logic                             active_reg,  active_next;
    logic                             major_y_reg, major_y_next;
    logic                             desc_reg,    desc_next;
    logic [POS_BITS-1:0]              pos_reg,     pos_next;
    logic [POS_BITS-1:0]              end_reg,     end_next;
    logic [AW-1:0]                    acc_reg,     acc_next;
    logic [AW-1:0]                    inc_reg,     inc_next;
    logic [brl_pkg::COLOR_BITS-1:0]   color_reg,   color_next;

    // divider
    logic [POS_BITS:0]                rem_reg,     rem_next;
    logic [POS_BITS-1:0]              den_reg,     den_next;
    logic [QW-1:0]                    quo_reg,     quo_next;
    logic                             neg_reg,     neg_next;
    logic                             dzero_reg,   dzero_next;

    // output register
    logic                             ovalid_reg,  ovalid_next;
    logic                             owr_reg,     owr_next;
    logic [IW-1:0]                    oidx_reg,    oidx_next;
    logic [brl_pkg::COLOR_BITS-1:0]   ocol_reg,    ocol_next;
    logic                             odone_reg,   odone_next;

    // setup
    logic [POS_BITS-1:0] xa_raw, ya_raw, xb_raw, yb_raw;
    logic [POS_BITS-1:0] xa, ya, xb, yb;
    logic [POS_BITS-1:0] band_first_p, band_last_p;
    logic [POS_BITS:0]   dx, dx_negated;
    logic                dx_neg;
    logic [POS_BITS-1:0] adx, dy;
    logic                major_y;
    logic                reject;
    logic [POS_BITS-1:0] minor_start;

    // divider step
    logic                div_ge;
    logic [POS_BITS:0]   div_sub;
    logic [QW-1:0]       quo_final;
    logic [AW-1:0]       quo_ext;

    // pixel
    logic [IW-1:0]       minor16, pos16, row, col, band_first16, band_last16;
    logic [IW-1:0]       row_off, row_mul;
    logic                in_band;

    assign xa_raw = POS_BITS'(x_start) + POS_BITS'(cfg.offset_x);
    assign ya_raw = POS_BITS'(y_start) + POS_BITS'(cfg.offset_y);
    assign xb_raw = POS_BITS'(x_end)   + POS_BITS'(cfg.offset_x);
    assign yb_raw = POS_BITS'(y_end)   + POS_BITS'(cfg.offset_y);

    always_comb
    begin
        if (ya_raw > yb_raw)
        begin
            xa = xb_raw; ya = yb_raw; xb = xa_raw; yb = ya_raw;
        end
        else
        begin
            xa = xa_raw; ya = ya_raw; xb = xb_raw; yb = yb_raw;
        end
    end

    assign band_first_p = POS_BITS'(cfg.band_first);
    assign band_last_p  = POS_BITS'(cfg.band_last);
    assign reject       = !((yb >= band_first_p) && (ya <= band_last_p));

    assign dy         = yb - ya;
    assign dx         = {1'b0, xb} - {1'b0, xa};
    assign dx_neg     = dx[POS_BITS];
    assign dx_negated = -dx;
    assign adx        = dx_neg ? dx_negated[POS_BITS-1:0] : dx[POS_BITS-1:0];
    assign major_y    = dy > adx;
    assign minor_start = major_y ? xa : ya;

    assign status.reject   = reject;
    assign status.out_free = !ovalid_reg || out_ready;

    // one restoring step: quotient bit, then shift remainder
    assign div_ge    = rem_reg >= {1'b0, den_reg};
    assign div_sub   = div_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    assign quo_final = {quo_reg[QW-2:0], div_ge};
    assign quo_ext   = AW'(quo_final);

    assign minor16      = acc_reg[AW-1:brl_pkg::FRAC_BITS];
    assign pos16        = IW'(pos_reg);
    assign row          = major_y_reg ? pos16 : minor16;
    assign col          = major_y_reg ? minor16 : pos16;
    assign band_first16 = IW'(cfg.band_first);
    assign band_last16  = IW'(cfg.band_last);
    assign in_band      = (row >= band_first16) && (row <= band_last16);
    assign row_off      = row - band_first16;
    assign row_mul      = row_off * IW'(cfg.row_width);

    always_comb
    begin
        active_next  = active_reg;
        major_y_next = major_y_reg;
        desc_next    = desc_reg;
        pos_next     = pos_reg;
        end_next     = end_reg;
        acc_next     = acc_reg;
        inc_next     = inc_reg;
        color_next   = color_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        quo_next     = quo_reg;
        neg_next     = neg_reg;
        dzero_next   = dzero_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        owr_next     = owr_reg;
        oidx_next    = oidx_reg;
        ocol_next    = ocol_reg;
        odone_next   = odone_reg;

        if (cmd.start)
        begin
            ovalid_next = 1'b1;
            owr_next    = 1'b0;
            oidx_next   = '0;
            ocol_next   = '0;
            odone_next  = reject;
            if (reject)
            begin
                active_next = 1'b0;
            end
            else
            begin
                active_next  = 1'b1;
                major_y_next = major_y;
                desc_next    = !major_y && dx_neg;
                pos_next     = major_y ? ya : xa;
                end_next     = major_y ? yb : xb;
                acc_next     = (AW'(minor_start) << brl_pkg::FRAC_BITS)
                               | brl_pkg::ROUND_HALF;
                color_next   = line_color;
                rem_next     = {1'b0, (major_y ? adx : dy)};
                den_next     = major_y ? dy : adx;
                quo_next     = '0;
                neg_next     = major_y && dx_neg;
                dzero_next   = (major_y ? dy : adx) == '0;
            end
        end
        else if (cmd.step)
        begin
            ovalid_next = 1'b1;
            owr_next    = 1'b0;
            oidx_next   = '0;
            ocol_next   = '0;
            odone_next  = 1'b1;
            if (active_reg)
            begin
                if (in_band)
                begin
                    owr_next  = 1'b1;
                    oidx_next = row_mul + col;
                    ocol_next = color_reg;
                end
                if (pos_reg == end_reg)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    odone_next = 1'b0;
                    pos_next   = desc_reg ? pos_reg - 1'b1 : pos_reg + 1'b1;
                    acc_next   = acc_reg + inc_reg;
                end
            end
        end

        if (cmd.div_step)
        begin
            rem_next = {div_sub[POS_BITS-1:0], 1'b0};
            quo_next = quo_final;
            if (cmd.div_last)
            begin
                if (dzero_reg)
                    inc_next = '0;
                else if (neg_reg)
                    inc_next = -quo_ext;
                else
                    inc_next = quo_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        major_y_reg <= major_y_next;
        desc_reg    <= desc_next;
        pos_reg     <= pos_next;
        end_reg     <= end_next;
        acc_reg     <= acc_next;
        inc_reg     <= inc_next;
        color_reg   <= color_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        quo_reg     <= quo_next;
        neg_reg     <= neg_next;
        dzero_reg   <= dzero_next;
        owr_reg     <= owr_next;
        oidx_reg    <= oidx_next;
        ocol_reg    <= ocol_next;
        odone_reg   <= odone_next;
    end

    assign out_valid   = ovalid_reg;
    assign write_valid = owr_reg;
    assign pixel_index = oidx_reg;
    assign pixel_color = ocol_reg;
    assign line_done   = odone_reg;

endmodule

### hdl/banded_line_rasterizer.sv
// Banded line rasterizer top level: stream ports, APB config, ctrl + datapath.
// Every item gives its result in the output register in the cycle after accept.
// Throughput: step items one per cycle while the output is not stalled; a start item
// that is not rejected then holds off the input for the bit-per-cycle restoring divider.
// Reset (rst_n, async, low): no line active, output empty, registers at defaults.
module banded_line_rasterizer
#(
    parameter int COORD_BITS = brl_pkg::DEF_COORD_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // x_start, y_start, x_end, y_end, line_color (zero padded to bytes)
    input  logic [((4*COORD_BITS+brl_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pixel_index, pixel_color
    output logic [brl_pkg::INDEX_BITS+brl_pkg::COLOR_BITS-1:0] m_axis_tdata,
    // write_valid
    output logic                            m_axis_tuser,
    // line_done
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [brl_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [brl_pkg::DATA_BITS-1:0]   pwdata,
    output logic [brl_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready
);

    localparam int POS_BITS = ((COORD_BITS > brl_pkg::OFFSET_BITS) ?
                               COORD_BITS : brl_pkg::OFFSET_BITS) + 1;
    localparam int CB = COORD_BITS;

    brl_pkg::cfg_t         cfg;
    brl_pkg::ctrl_cmd_t    cmd;
    brl_pkg::ctrl_status_t status;
    logic [brl_pkg::INDEX_BITS-1:0] pixel_index;
    logic [brl_pkg::COLOR_BITS-1:0] pixel_color;

    brl_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    brl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    brl_datapath
    #(
        .COORD_BITS (COORD_BITS),
        .POS_BITS   (POS_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .x_start     (s_axis_tdata[CB-1:0]),
        .y_start     (s_axis_tdata[2*CB-1:CB]),
        .x_end       (s_axis_tdata[3*CB-1:2*CB]),
        .y_end       (s_axis_tdata[4*CB-1:3*CB]),
        .line_color  (s_axis_tdata[4*CB+brl_pkg::COLOR_BITS-1:4*CB]),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .write_valid (m_axis_tuser),
        .pixel_index (pixel_index),
        .pixel_color (pixel_color),
        .line_done   (m_axis_tlast)
    );

    assign m_axis_tdata = {pixel_color, pixel_index};

endmodule

### hdl/brl_checker.sv
// Port-level checker for banded_line_rasterizer, attached with bind.
// Depends on brl_pkg.
module brl_checker
(
    input logic                                             clk,
    input logic                                             rst_n,
    input logic                                             s_axis_tvalid,
    input logic                                             s_axis_tready,
    input logic                                             s_axis_tuser,
    input logic                                             m_axis_tvalid,
    input logic                                             m_axis_tready,
    input logic [brl_pkg::INDEX_BITS+brl_pkg::COLOR_BITS-1:0] m_axis_tdata,
    input logic                                             m_axis_tuser,
    input logic                                             m_axis_tlast
);

    logic start_acc;

    assign start_acc = s_axis_tvalid && s_axis_tready
                       && (brl_pkg::op_t'(s_axis_tuser) == brl_pkg::OP_START);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // start item answers next cycle with a non-write result
    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        start_acc |=> m_axis_tvalid && !m_axis_tuser)
        else $error("start item gave no empty result");

    // accepted start: either rejected, or input held off for the divide
    a_start_divide: assert property (@(posedge clk) disable iff (!rst_n)
        start_acc |=> m_axis_tlast || !s_axis_tready)
        else $error("input taken during divide");

    // non-write results carry zero payload
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("non-write result with payload");

endmodule

bind banded_line_rasterizer brl_checker u_brl_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
